FILE: rtl/core/plss_pkg.sv
// ----------------------------------------------------------------------------
// Powered leak sensor scanner package
// Shared widths, register indexes and register reset values.
// ----------------------------------------------------------------------------
package plss_pkg;

   localparam int TIME_W   = 32;
   localparam int LEVEL_W  = 8;
   localparam int COUNT_W  = 8;
   localparam int SCOUNT_W = 4;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   // Configuration register indexes.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ACTIVE_LEVEL    = 3'd0,
      CSR_POWER_GATING    = 3'd1,
      CSR_CHECK_INTERVAL  = 3'd2,
      CSR_POWER_LEAD_TIME = 3'd3,
      CSR_ALARM_THRESHOLD = 3'd4,
      CSR_SENSOR_COUNT    = 3'd5
   } csr_index_type;

   // Request function codes.
   localparam logic FUNC_TICK  = 1'b0;
   localparam logic FUNC_CLEAR = 1'b1;

   localparam logic                RST_ACTIVE_LEVEL    = 1'b0;
   localparam logic                RST_POWER_GATING    = 1'b1;
   localparam logic [TIME_W-1:0]   RST_CHECK_INTERVAL  = 32'd1000;
   localparam logic [TIME_W-1:0]   RST_POWER_LEAD_TIME = 32'd100;
   localparam logic [COUNT_W-1:0]  RST_ALARM_THRESHOLD = 8'd3;
   localparam logic [SCOUNT_W-1:0] RST_SENSOR_COUNT    = 4'd8;

   localparam logic [COUNT_W-1:0]  COUNT_MAX = 8'd255;

endpackage

FILE: rtl/core/plss_if.sv
// ----------------------------------------------------------------------------
// Powered leak sensor scanner channels
// Request and response channels with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface plss_req_if;
   import plss_pkg::*;

   logic                 valid;
   logic                 ready;
   logic                 func;
   logic [TIME_W-1:0]    now_ms;
   logic                 system_alarm;
   logic [LEVEL_W-1:0]   sensor_levels;

   modport source (output valid, func, now_ms, system_alarm, sensor_levels, input ready);
   modport sink   (input valid, func, now_ms, system_alarm, sensor_levels, output ready);
endinterface

interface plss_rsp_if;
   import plss_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [LEVEL_W-1:0]   alarm_mask;
   logic                 power_drive;
   logic                 scanned;

   modport source (output valid, alarm_mask, power_drive, scanned, input ready);
   modport sink   (input valid, alarm_mask, power_drive, scanned, output ready);
endinterface

FILE: rtl/core/powered_leak_sensor_scanner.sv
// ----------------------------------------------------------------------------
// Powered leak sensor scanner
// Debounces leak sensors by counting consecutive active checks, with sensor
// power raised only around each check when power gating is enabled.
// ----------------------------------------------------------------------------
// An accepted request waits in the item registers until the response register can take it.
// Throughput: one request per cycle while the response side keeps up; the
// count row read-modify-write is covered by forwarding the row being written.
// Reset (synchronous, active high) restores register defaults, clears time,
// power and measured state, and marks the count row as all zero at once.
// ----------------------------------------------------------------------------
module powered_leak_sensor_scanner #(
   parameter int NUM_SENSORS = 8
) (
   input  logic                                  clock,
   input  logic                                  reset,
   plss_req_if.sink                              req_ch,
   plss_rsp_if.source                            rsp_ch,
   input  logic                                  csr_we,
   input  logic [plss_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [plss_pkg::CSR_DATA_W-1:0]       csr_wdata
);
   import plss_pkg::*;

   // One memory row holds every sensor's count side by side.
   localparam int ROW_W = NUM_SENSORS * COUNT_W;
   // Level and mask vectors are padded so that every lane has a bit to index.
   localparam int EXT_W = (NUM_SENSORS > LEVEL_W) ? NUM_SENSORS : LEVEL_W;

   // Configuration registers.
   logic                active_level_ff;
   logic                power_gating_ff;
   logic [TIME_W-1:0]   check_interval_ff;
   logic [TIME_W-1:0]   power_lead_time_ff;
   logic [COUNT_W-1:0]  alarm_threshold_ff;
   logic [SCOUNT_W-1:0] sensor_count_ff;

   // Scalar scanner state.
   logic [TIME_W-1:0]   last_check_ff, last_check_in;
   logic                measured_ff, measured_in;
   logic                power_ff, power_in;

   // Request held while its count row is being read.
   logic                busy_ff;
   logic                item_func_ff;
   logic [TIME_W-1:0]   item_now_ff;
   logic                item_sys_alarm_ff;
   logic [LEVEL_W-1:0]  item_levels_ff;

   // Count memory, its read data and the forwarding path.
   logic [ROW_W-1:0]    cnt_mem [1];
   logic [ROW_W-1:0]    rd_data_ff;
   logic                rd_valid_ff;
   logic                cnt_valid_ff;
   logic                fwd_ff;
   logic [ROW_W-1:0]    fwd_data_ff;

   // Response register.
   logic                rsp_valid_ff;
   logic [LEVEL_W-1:0]  rsp_mask_ff, rsp_mask_in;
   logic                rsp_scanned_ff, rsp_scanned_in;

   logic                accept;
   logic                can_finish;
   logic                finish;
   logic                mem_we;
   logic [ROW_W-1:0]    row_cur;
   logic [ROW_W-1:0]    row_out;
   logic [TIME_W-1:0]   elapsed;
   logic [TIME_W-1:0]   early;
   logic                go;
   logic [EXT_W-1:0]    levels_ext;
   logic [EXT_W-1:0]    mask_ext;
   logic                any_alarm;

   // The pending request completes once the response register can take it.
   // A new request may be accepted in the same cycle, as its row read is
   // covered by forwarding the row being written.
   assign can_finish   = !rsp_valid_ff || rsp_ch.ready;
   assign finish       = busy_ff && can_finish;
   assign req_ch.ready = !busy_ff || can_finish;
   assign accept       = req_ch.valid && req_ch.ready;

   // A row never written since reset reads as all zero counts.
   assign row_cur = fwd_ff      ? fwd_data_ff :
                    rd_valid_ff ? rd_data_ff  : '0;

   assign elapsed = item_now_ff - last_check_ff;
   assign early   = (check_interval_ff > power_lead_time_ff) ?
                    (check_interval_ff - power_lead_time_ff) : '0;
   assign levels_ext = EXT_W'(item_levels_ff);

   // Tick decision: suspension, time going backward, the power-up window
   // under gating, and the plain interval check without it.
   always_comb begin
      last_check_in = last_check_ff;
      measured_in   = measured_ff;
      power_in      = power_ff;
      go            = 1'b0;
      if (item_func_ff == FUNC_TICK && !item_sys_alarm_ff) begin
         if (last_check_ff > item_now_ff) begin
            last_check_in = item_now_ff;
         end else if (power_gating_ff) begin
            if (elapsed >= early) begin
               if (!power_ff && !measured_ff) begin
                  power_in = 1'b1;
               end else if (power_ff && measured_ff) begin
                  last_check_in = item_now_ff;
                  power_in      = 1'b0;
                  measured_in   = 1'b0;
               end else if (elapsed >= check_interval_ff) begin
                  measured_in = 1'b1;
                  go          = 1'b1;
               end
            end
         end else if (elapsed >= check_interval_ff) begin
            last_check_in = item_now_ff;
            go            = 1'b1;
         end
      end

      // Sensor lanes, each updated on its own.
      row_out   = row_cur;
      mask_ext  = '0;
      any_alarm = 1'b0;
      if (item_func_ff == FUNC_CLEAR) begin
         row_out = '0;
      end else if (go) begin
         for (int i = 0; i < NUM_SENSORS; i++) begin
            if (i < int'(sensor_count_ff)) begin
               if (levels_ext[i] == active_level_ff) begin
                  if (row_cur[i*COUNT_W +: COUNT_W] != COUNT_MAX) begin
                     row_out[i*COUNT_W +: COUNT_W] =
                        row_cur[i*COUNT_W +: COUNT_W] + COUNT_W'(1);
                  end
                  if (row_out[i*COUNT_W +: COUNT_W] >= alarm_threshold_ff) begin
                     mask_ext[i] = 1'b1;
                     any_alarm   = 1'b1;
                  end
               end else begin
                  row_out[i*COUNT_W +: COUNT_W] = '0;
               end
            end
         end
      end
      // An alarm anywhere in the scan cuts power and restarts the cycle.
      if (any_alarm) begin
         power_in    = 1'b0;
         measured_in = 1'b0;
      end

      rsp_mask_in    = mask_ext[LEVEL_W-1:0];
      rsp_scanned_in = go;
   end

   assign mem_we = finish && (item_func_ff == FUNC_CLEAR || go);

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         active_level_ff    <= RST_ACTIVE_LEVEL;
         power_gating_ff    <= RST_POWER_GATING;
         check_interval_ff  <= RST_CHECK_INTERVAL;
         power_lead_time_ff <= RST_POWER_LEAD_TIME;
         alarm_threshold_ff <= RST_ALARM_THRESHOLD;
         sensor_count_ff    <= RST_SENSOR_COUNT;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_ACTIVE_LEVEL:    active_level_ff    <= csr_wdata[0];
            CSR_POWER_GATING:    power_gating_ff    <= csr_wdata[0];
            CSR_CHECK_INTERVAL:  check_interval_ff  <= csr_wdata[TIME_W-1:0];
            CSR_POWER_LEAD_TIME: power_lead_time_ff <= csr_wdata[TIME_W-1:0];
            CSR_ALARM_THRESHOLD: alarm_threshold_ff <= csr_wdata[COUNT_W-1:0];
            CSR_SENSOR_COUNT:    sensor_count_ff    <= csr_wdata[SCOUNT_W-1:0];
            default: ;
         endcase
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         cnt_valid_ff  <= 1'b0;
         fwd_ff        <= 1'b0;
         rd_valid_ff   <= 1'b0;
         last_check_ff <= '0;
         measured_ff   <= 1'b0;
         power_ff      <= 1'b0;
      end else begin
         if (accept) begin
            busy_ff     <= 1'b1;
            fwd_ff      <= mem_we;
            rd_valid_ff <= cnt_valid_ff || mem_we;
         end else if (finish) begin
            busy_ff <= 1'b0;
            fwd_ff  <= 1'b0;
         end
         if (finish) begin
            rsp_valid_ff  <= 1'b1;
            last_check_ff <= last_check_in;
            measured_ff   <= measured_in;
            power_ff      <= power_in;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (mem_we) begin
            cnt_valid_ff <= 1'b1;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (accept) begin
         item_func_ff      <= req_ch.func;
         item_now_ff       <= req_ch.now_ms;
         item_sys_alarm_ff <= req_ch.system_alarm;
         item_levels_ff    <= req_ch.sensor_levels;
         rd_data_ff        <= cnt_mem[0];
         fwd_data_ff       <= row_out;
      end
      if (finish) begin
         rsp_mask_ff    <= rsp_mask_in;
         rsp_scanned_ff <= rsp_scanned_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         cnt_mem[0] <= row_out;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.alarm_mask  = rsp_mask_ff;
   assign rsp_ch.power_drive = power_ff;
   assign rsp_ch.scanned     = rsp_scanned_ff;

`ifndef NO_ASSERTIONS
   // A request waiting on a full response register stays pending.
   a_busy_hold: assert property (@(posedge clock) disable iff (reset)
      busy_ff && !can_finish |=> busy_ff)
      else $error("pending request lost while response stalled");

   // Forwarded data only ever belongs to a pending request.
   a_fwd_busy: assert property (@(posedge clock) disable iff (reset)
      fwd_ff |-> busy_ff)
      else $error("forwarding flag set with no pending request");

   // A response that did not scan carries no alarm bits.
   a_mask_scan: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_scanned_ff |-> rsp_mask_ff == '0)
      else $error("alarm bits reported without a scan");

   // Once the count row has been written it stays valid until reset.
   a_row_valid: assert property (@(posedge clock) disable iff (reset)
      mem_we |=> cnt_valid_ff)
      else $error("count row not marked valid after a write");
`endif

endmodule
